/* design/mpt_pkg.sv */
// ----------------------------------------------------------------------------
// mpt_pkg
// shared constants, codes and the crc-8 byte update for the packet transmitter
// ----------------------------------------------------------------------------
package mpt_pkg;

  localparam int DATA_BYTES_DEFAULT = 4;

  localparam logic [7:0] PREAMBLE = 8'h55;
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam int         BITS_PER_BYTE = 8;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // msb-first crc-8, one byte
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < BITS_PER_BYTE; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* design/mpt_if.sv */
// ----------------------------------------------------------------------------
// mpt_if
// valid/ready channels for load and tick transactions and their results
// ----------------------------------------------------------------------------
interface mpt_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface mpt_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic accepted;
  logic frame_done;

  modport source (output valid, output line_level, output busy_res, output accepted,
                  output frame_done, input ready);
  modport sink   (input valid, input line_level, input busy_res, input accepted,
                  input frame_done, output ready);
endinterface

/* design/manchester_packet_transmitter.sv */
// ----------------------------------------------------------------------------
// manchester_packet_transmitter
// collects payload bytes, frames them with preamble and crc-8, and sends the
// frame as manchester code, one line level per tick transaction
// ----------------------------------------------------------------------------
// Each input transaction (a payload load or a transmit tick) gives exactly one
// result transaction, which appears in the output register in the cycle after the
// input is accepted. The block takes one transaction every cycle: the whole
// state update for an item is one pass of logic into the state registers, and
// a new item can enter in the same cycle the previous result is taken; while a
// result waits on the output, the input is held off.
// Loads are refused while a frame is armed or on the line; a frame takes
// 2 + 16 * (DATA_BYTES + 2) ticks, start half-bit and final low tick included.
module manchester_packet_transmitter #(
  parameter int DATA_BYTES = mpt_pkg::DATA_BYTES_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  mpt_in_if.sink           in_ch,
  mpt_out_if.source        out_ch
);

  localparam int IDX_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
  localparam int PW    = $clog2(DATA_BYTES + 2);
  localparam logic [IDX_W-1:0] LAST_LOAD = IDX_W'(DATA_BYTES - 1);
  localparam logic [PW-1:0]    LAST_BYTE = PW'(DATA_BYTES + 1);

  logic [7:0]       payload [DATA_BYTES];
  logic [7:0]       crc_frame;
  logic [IDX_W-1:0] load_count, load_count_next;
  logic [7:0]       crc_reg, crc_reg_next;
  logic [PW-1:0]    byte_pos, byte_pos_next;
  logic [2:0]       bit_pos, bit_pos_next;
  logic             second_half, second_half_next;
  logic             start_sent, start_sent_next;
  logic             end_phase, end_phase_next;
  logic             busy_flag, busy_flag_next;
  logic             line_reg, line_reg_next;

  logic             out_valid;
  logic             line_level, busy_res, accepted, frame_done;
  logic             accepted_next, frame_done_next;

  logic             in_fire;
  logic             store_en, crc_frame_en;
  logic [7:0]       crc_upd;
  logic [PW-1:0]    byte_sub;
  logic [IDX_W-1:0] pay_idx;
  logic [7:0]       cur_byte;
  logic             cur_bit;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign crc_upd  = mpt_pkg::crc8_update(crc_reg, in_ch.data_byte);
  assign byte_sub = byte_pos - PW'(1);
  assign pay_idx  = byte_sub[IDX_W-1:0];

  always_comb begin
    if (byte_pos == '0) begin
      cur_byte = mpt_pkg::PREAMBLE;
    end else if (byte_pos == LAST_BYTE) begin
      cur_byte = crc_frame;
    end else begin
      cur_byte = payload[pay_idx];
    end
  end

  assign cur_bit = cur_byte[bit_pos];

  always_comb begin
    load_count_next  = load_count;
    crc_reg_next     = crc_reg;
    byte_pos_next    = byte_pos;
    bit_pos_next     = bit_pos;
    second_half_next = second_half;
    start_sent_next  = start_sent;
    end_phase_next   = end_phase;
    busy_flag_next   = busy_flag;
    line_reg_next    = line_reg;
    accepted_next    = 1'b0;
    frame_done_next  = 1'b0;
    store_en         = 1'b0;
    crc_frame_en     = 1'b0;
    case (in_ch.mode)
      mpt_pkg::MODE_LOAD: begin
        if (!busy_flag) begin
          accepted_next = 1'b1;
          store_en      = 1'b1;
          if (load_count == LAST_LOAD) begin
            crc_frame_en     = 1'b1;
            crc_reg_next     = mpt_pkg::CRC_INIT;
            load_count_next  = '0;
            byte_pos_next    = '0;
            bit_pos_next     = '0;
            second_half_next = 1'b0;
            start_sent_next  = 1'b0;
            end_phase_next   = 1'b0;
            busy_flag_next   = 1'b1;
          end else begin
            crc_reg_next    = crc_upd;
            load_count_next = load_count + IDX_W'(1);
          end
        end
      end
      mpt_pkg::MODE_TICK: begin
        if (busy_flag) begin
          if (end_phase) begin
            end_phase_next  = 1'b0;
            start_sent_next = 1'b0;
            line_reg_next   = 1'b0;
            busy_flag_next  = 1'b0;
            frame_done_next = 1'b1;
          end else if (!start_sent) begin
            start_sent_next = 1'b1;
            line_reg_next   = 1'b1;
          end else if (!second_half) begin
            line_reg_next    = cur_bit;
            second_half_next = 1'b1;
          end else begin
            line_reg_next    = !cur_bit;
            second_half_next = 1'b0;
            bit_pos_next     = bit_pos + 3'd1;
            if (bit_pos == 3'd7) begin
              if (byte_pos == LAST_BYTE) begin
                byte_pos_next  = '0;
                end_phase_next = 1'b1;
              end else begin
                byte_pos_next = byte_pos + PW'(1);
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count  <= '0;
      crc_reg     <= mpt_pkg::CRC_INIT;
      byte_pos    <= '0;
      bit_pos     <= '0;
      second_half <= 1'b0;
      start_sent  <= 1'b0;
      end_phase   <= 1'b0;
      busy_flag   <= 1'b0;
      line_reg    <= 1'b0;
    end else if (in_fire) begin
      load_count  <= load_count_next;
      crc_reg     <= crc_reg_next;
      byte_pos    <= byte_pos_next;
      bit_pos     <= bit_pos_next;
      second_half <= second_half_next;
      start_sent  <= start_sent_next;
      end_phase   <= end_phase_next;
      busy_flag   <= busy_flag_next;
      line_reg    <= line_reg_next;
    end
  end

  // payload store and frame crc
  always_ff @(posedge clk) begin
    if (in_fire && store_en) begin
      payload[load_count] <= in_ch.data_byte;
    end
    if (in_fire && crc_frame_en) begin
      crc_frame <= crc_upd;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      line_level <= line_reg_next;
      busy_res   <= busy_flag_next;
      accepted   <= accepted_next;
      frame_done <= frame_done_next;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.line_level = line_level;
  assign out_ch.busy_res   = busy_res;
  assign out_ch.accepted   = accepted;
  assign out_ch.frame_done = frame_done;

`ifndef SYNTHESIS
  a_done_clears_busy: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.frame_done |-> !out_ch.busy_res)
    else $error("frame_done with busy still set");

  a_refuse_when_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire && (in_ch.mode == mpt_pkg::MODE_LOAD) && busy_flag
      |=> out_ch.valid && !out_ch.accepted)
    else $error("load accepted while busy");

  a_end_phase_busy: assert property (@(posedge clk) disable iff (rst)
    end_phase |-> busy_flag && start_sent)
    else $error("end phase outside a frame");

  a_start_at_origin: assert property (@(posedge clk) disable iff (rst)
    !start_sent |-> byte_pos == '0 && bit_pos == 3'd0 && !second_half)
    else $error("frame position not at origin before start half-bit");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the manchester packet transmitter. Payload loads and
// transmit ticks are queued up front, driven in random bursts and checked
// against an in-bench predictor of the framing, crc-8 and manchester line
// levels, while the result side stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_top;

  import mpt_pkg::*;

  localparam int DATA_BYTES  = DATA_BYTES_DEFAULT;
  localparam int FRAME_BYTES = DATA_BYTES + 2;
  localparam int HOLD_CYCLES = 64;
  localparam int ITEM_TARGET = 700;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       drain_first;
    logic       hold_rx;
  } tx_item_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } tx_result_t;

  typedef struct packed {
    logic [FRAME_BYTES-1:0][7:0] frame;
    logic [7:0]                  loaded;
    logic [7:0]                  crc;
    logic [7:0]                  byte_idx;
    logic [2:0]                  bit_idx;
    logic                        second_half;
    logic                        start_done;
    logic                        ending;
    logic                        busy;
    logic                        line;
  } tx_state_t;

  logic clk;
  logic rst;

  mpt_in_if  in_ch();
  mpt_out_if out_ch();

  manchester_packet_transmitter #(.DATA_BYTES(DATA_BYTES)) DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tx_item_t   pending_q[$];
  tx_result_t expected_q[$];
  tx_state_t  line_model;
  tx_state_t  plan_model;

  int err_count;
  int n_results;
  int n_frames;
  int n_loads_taken;
  int n_loads_refused;
  int n_ticks;
  int n_useful;

  int burst_left;
  int gap_left;
  int hold_left;
  logic hold_kick;
  int rx_mode;
  int rx_mode_left;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // msb-first crc-8, one data bit at a time
  function automatic logic [7:0] crc_after_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
    end
    return c;
  endfunction

  function automatic tx_state_t idle_state();
    tx_state_t s;
    s = '0;
    s.crc = CRC_INIT;
    return s;
  endfunction

  function automatic tx_result_t line_step(inout tx_state_t s, input tx_item_t it);
    tx_result_t r;
    logic       cur_bit;
    r = '0;
    if (it.mode == MODE_LOAD) begin
      if (!s.busy) begin
        s.frame[1 + s.loaded] = it.data_byte;
        s.crc = crc_after_byte(s.crc, it.data_byte);
        s.loaded = s.loaded + 8'd1;
        if (s.loaded == DATA_BYTES) begin
          s.frame[0] = PREAMBLE;
          s.frame[FRAME_BYTES-1] = s.crc;
          s.crc = CRC_INIT;
          s.loaded = '0;
          s.byte_idx = '0;
          s.bit_idx = '0;
          s.second_half = 1'b0;
          s.start_done = 1'b0;
          s.ending = 1'b0;
          s.busy = 1'b1;
        end
        r.accepted = 1'b1;
      end
    end else if (s.busy) begin
      if (s.ending) begin
        s.ending = 1'b0;
        s.start_done = 1'b0;
        s.line = 1'b0;
        s.busy = 1'b0;
        r.frame_done = 1'b1;
      end else if (!s.start_done) begin
        s.start_done = 1'b1;
        s.line = 1'b1;
      end else begin
        cur_bit = s.frame[s.byte_idx][s.bit_idx];
        if (!s.second_half) begin
          s.line = cur_bit;
          s.second_half = 1'b1;
        end else begin
          s.line = ~cur_bit;
          s.second_half = 1'b0;
          s.bit_idx = s.bit_idx + 3'd1;
          if (s.bit_idx == 3'd0) begin
            s.byte_idx = s.byte_idx + 8'd1;
            if (s.byte_idx == FRAME_BYTES) begin
              s.byte_idx = '0;
              s.ending = 1'b1;
            end
          end
        end
      end
    end
    r.line_level = s.line;
    r.busy_res = s.busy;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < 40) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic queue_item(input logic mode, input logic [7:0] b, input logic drain_first,
                            input logic hold_rx);
    tx_item_t   it;
    tx_result_t r;
    logic       was_busy;
    it.mode = mode;
    it.data_byte = b;
    it.drain_first = drain_first;
    it.hold_rx = hold_rx;
    was_busy = plan_model.busy;
    r = line_step(plan_model, it);
    pending_q.push_back(it);
    if ((mode == MODE_LOAD) ? r.accepted : was_busy) begin
      n_useful++;
    end
  endtask

  task automatic queue_packet(input logic drain_first, input logic hold_rx);
    logic first;
    first = 1'b1;
    while (!plan_model.busy) begin
      if ($urandom_range(0, 7) == 0) begin
        queue_item(MODE_TICK, 8'($urandom), drain_first && first, 1'b0);
      end else begin
        queue_item(MODE_LOAD, 8'($urandom), drain_first && first, 1'b0);
      end
      first = 1'b0;
    end
    first = 1'b1;
    while (plan_model.busy) begin
      if ($urandom_range(0, 9) == 0) begin
        queue_item(MODE_LOAD, 8'($urandom), 1'b0, 1'b0);
      end else begin
        queue_item(MODE_TICK, 8'($urandom), 1'b0, hold_rx && first);
        first = 1'b0;
      end
    end
  endtask

  // driver
  always @(posedge clk) begin : drv
    tx_item_t   head;
    tx_result_t want;
    logic       was_busy;
    logic       drive;
    logic       kick;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.mode <= MODE_LOAD;
      in_ch.data_byte <= 8'h00;
      hold_kick <= 1'b0;
      line_model = idle_state();
      burst_left = $urandom_range(1, 24);
      gap_left = 0;
    end else begin
      drive = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        head = pending_q.pop_front();
        was_busy = line_model.busy;
        want = line_step(line_model, head);
        expected_q.push_back(want);
        if (head.mode == MODE_LOAD) begin
          if (want.accepted) n_loads_taken++;
          else n_loads_refused++;
        end else if (was_busy) begin
          n_ticks++;
        end
        drive = 1'b0;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      kick = 1'b0;
      if (!drive) begin
        if (gap_left > 0 && hold_left == 0) begin
          gap_left--;
        end else if (pending_q.size() > 0) begin
          if (!(pending_q[0].drain_first && expected_q.size() > 0)) begin
            drive = 1'b1;
            kick = pending_q[0].hold_rx;
            pending_q[0].drain_first = 1'b0;
            pending_q[0].hold_rx = 1'b0;
          end
        end
      end
      in_ch.valid <= drive;
      if (drive) begin
        in_ch.mode <= pending_q[0].mode;
        in_ch.data_byte <= pending_q[0].data_byte;
      end
      hold_kick <= kick;
    end
  end

  // receiver stall pattern plus the occasional long hold-off
  always @(posedge clk) begin : rcv
    logic pat;
    if (rst) begin
      out_ch.ready <= 1'b0;
      hold_left <= 0;
      rx_mode = 0;
      rx_mode_left = 0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_mode_left = $urandom_range(10, 60);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        0: begin
          pat = 1'b1;
        end
        1: begin
          pat = $urandom_range(0, 1) == 0;
        end
        default: begin
          pat = $urandom_range(0, 3) == 0;
        end
      endcase
      if (hold_kick) begin
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= pat;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : mon
    tx_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (out_ch.frame_done) n_frames++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result transaction %0d arrived with nothing expected",
                                  n_results));
      end else begin
        want = expected_q.pop_front();
        if (out_ch.line_level !== want.line_level)
          report_mismatch($sformatf("result %0d line_level got %b expected %b", n_results,
                                    out_ch.line_level, want.line_level));
        if (out_ch.busy_res !== want.busy_res)
          report_mismatch($sformatf("result %0d busy_res got %b expected %b", n_results,
                                    out_ch.busy_res, want.busy_res));
        if (out_ch.accepted !== want.accepted)
          report_mismatch($sformatf("result %0d accepted got %b expected %b", n_results,
                                    out_ch.accepted, want.accepted));
        if (out_ch.frame_done !== want.frame_done)
          report_mismatch($sformatf("result %0d frame_done got %b expected %b", n_results,
                                    out_ch.frame_done, want.frame_done));
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout with %0d transactions pending, %0d results outstanding",
             pending_q.size(), expected_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stim
    logic [7:0] edge_bytes[4];
    int         packets;
    int         n_rand;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_LOAD;
    in_ch.data_byte = 8'h00;
    out_ch.ready = 1'b0;
    err_count = 0;
    n_results = 0;
    n_frames = 0;
    n_loads_taken = 0;
    n_loads_refused = 0;
    n_ticks = 0;
    n_useful = 0;
    plan_model = idle_state();
    edge_bytes[0] = 8'h00;
    edge_bytes[1] = 8'hFF;
    edge_bytes[2] = 8'h80;
    edge_bytes[3] = 8'h01;

    // directed: idle tick, extreme payload, refused load, full frame, idle tick, stored load
    queue_item(MODE_TICK, 8'hFF, 1'b0, 1'b0);
    for (int i = 0; i < DATA_BYTES; i++) begin
      queue_item(MODE_LOAD, edge_bytes[i % 4], 1'b0, 1'b0);
    end
    queue_item(MODE_LOAD, 8'hA5, 1'b0, 1'b0);
    packets = 0;
    while (plan_model.busy) begin
      queue_item(MODE_TICK, 8'($urandom), 1'b0, packets == 10);
      packets++;
    end
    queue_item(MODE_TICK, 8'h5A, 1'b1, 1'b0);
    queue_item(MODE_LOAD, 8'h7F, 1'b0, 1'b0);

    // random: mostly whole packets with noise, some loose items
    packets = 0;
    while (pending_q.size() < ITEM_TARGET) begin
      if ($urandom_range(0, 9) < 8) begin
        packets++;
        queue_packet(packets == 2, packets == 3 || packets == 5);
      end else begin
        n_rand = $urandom_range(1, 12);
        for (int i = 0; i < n_rand; i++) begin
          queue_item($urandom_range(0, 1) ? MODE_TICK : MODE_LOAD, 8'($urandom), 1'b0, 1'b0);
        end
      end
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() > 0) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (expected_q.size() > 0) begin
      report_mismatch("expected result never arrived");
      void'(expected_q.pop_front());
    end

    $display("covered %0d result transactions: %0d loads stored, %0d loads refused,",
             n_results, n_loads_taken, n_loads_refused);
    $display("%0d ticks on an active frame, %0d complete frames, %0d state-changing items; %0d mismatches",
             n_ticks, n_frames, n_useful, err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/mpt_pkg.sv
design/mpt_if.sv
design/manchester_packet_transmitter.sv
tb/sv/tb_top.sv
